@@ design/transaction_decision_hash_table_macros.svh @@
// Assertion helpers for the decision table. Bodies are empty in synthesis.
`ifndef TRANSACTION_DECISION_HASH_TABLE_MACROS_SVH
`define TRANSACTION_DECISION_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// cond holds at every clock edge outside reset
`define TDHT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: invariant");
// b holds in the same cycle as a
`define TDHT_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: implication");
// b holds in the cycle after a
`define TDHT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");
`else
`define TDHT_ASSERT_ALWAYS(label, clk, rst, cond)
`define TDHT_ASSERT_IMPLIES(label, clk, rst, a, b)
`define TDHT_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

@@ design/tdht_pkg.sv @@
package tdht_pkg;

   // table geometry
   localparam int NUM_BUCKETS = 256;
   localparam int WAYS        = 4;
   localparam int SLOTS       = NUM_BUCKETS * WAYS;

   // field widths
   localparam int MODE_W  = 2;
   localparam int ID_W    = 32;
   localparam int DEC_W   = 8;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 11;
   localparam int CFG_W   = 9;

   // bucket index and divisor widths
   localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int N_W   = $clog2(NUM_BUCKETS + 1);

   // remainder unit: bits of the id consumed per cycle
   localparam int MOD_BITS_PER_STEP = 4;
   localparam int MOD_STEPS         = ID_W / MOD_BITS_PER_STEP;
   localparam int STEP_W            = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   localparam logic [CFG_W-1:0] BUCKETS_RESET = CFG_W'(256);

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  key;
      logic [DEC_W-1:0] value;
   } slot_type;

   typedef slot_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic             en;
      logic [BKT_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic             en;
      logic [BKT_W-1:0] addr;
      row_type          row;
   } wr_req_type;

endpackage

@@ design/tdht_mod.sv @@
// Remainder of a 32-bit id by the bucket count, restoring style,
// MOD_BITS_PER_STEP bits per cycle.
module tdht_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tdht_pkg::ID_W-1:0]  id,
   input  logic [tdht_pkg::N_W-1:0]   divisor,
   output logic                       done,
   output logic [tdht_pkg::BKT_W-1:0] remainder
);
   import tdht_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [N_W-1:0]    div_ff, div_in;
   logic [N_W-1:0]    r_ff, r_in;
   logic [N_W-1:0]    r_step;

   // MOD_BITS_PER_STEP dependent compare/subtract steps on the partial remainder
   always_comb begin
      logic [N_W:0]   t;
      logic [N_W-1:0] r;
      r = r_ff;
      t = '0;
      for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
         t = {r, id_ff[ID_W-1-i]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         r = t[N_W-1:0];
      end
      r_step = r;
   end

   // sequencing
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      id_in   = id_ff;
      div_in  = div_ff;
      r_in    = r_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         id_in  = id;
         div_in = divisor;
         r_in   = '0;
      end else if (run_ff) begin
         r_in   = r_step;
         id_in  = id_ff << MOD_BITS_PER_STEP;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(MOD_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      div_ff <= div_in;
      r_ff   <= r_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff[BKT_W-1:0];

endmodule

@@ design/tdht_store.sv @@
// Bucket memory: one row of WAYS slots per bucket, registered read.
// A row never written reads as all slots empty (row-initialised flags).
module tdht_store (
   input  logic                   clock,
   input  logic                   reset,
   input  tdht_pkg::rd_req_type   rd_req,
   input  tdht_pkg::wr_req_type   wr_req,
   output tdht_pkg::row_type      rd_row
);
   import tdht_pkg::*;

   row_type                mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] row_init_ff;
   row_type                rd_row_ff;
   logic                   rd_init_ff;

   // row storage
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.row;
      end
      if (rd_req.en) begin
         rd_row_ff <= mem[rd_req.addr];
      end
   end

   // row-initialised flags
   always_ff @(posedge clock) begin
      if (reset) begin
         row_init_ff <= '0;
         rd_init_ff  <= 1'b0;
      end else begin
         if (wr_req.en) begin
            row_init_ff[wr_req.addr] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_init_ff <= row_init_ff[rd_req.addr];
         end
      end
   end

   assign rd_row = rd_init_ff ? rd_row_ff : '0;

endmodule

@@ design/transaction_decision_hash_table.sv @@
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+--------------------------
// request   | req_mode, req_transaction_id,                | taken when start & !busy
//           | req_decision_value                           |
// response  | rsp_found_decision, rsp_status,              | rsp_strobe, one cycle,
//           | rsp_entry_count                              | cannot be held off
// config    | csr_buckets_in_use                           | csr_valid & csr_ready
//
// An item passes from acceptance to its response strobe through the remainder
// unit (4 id bits per cycle), one memory read, one read-modify-write and the
// registered response. busy drops in the cycle the response is shown, so the
// next item can start then. Synchronous reset empties the table at once (per-row
// flags) and sets buckets_in_use to 256. The receiver cannot stall.
module transaction_decision_hash_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [tdht_pkg::MODE_W-1:0] req_mode,
   input  logic [tdht_pkg::ID_W-1:0]   req_transaction_id,
   input  logic [tdht_pkg::DEC_W-1:0]  req_decision_value,
   output logic                        rsp_strobe,
   output logic [tdht_pkg::DEC_W-1:0]  rsp_found_decision,
   output logic [tdht_pkg::STAT_W-1:0] rsp_status,
   output logic [tdht_pkg::CNT_W-1:0]  rsp_entry_count,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tdht_pkg::CFG_W-1:0]  csr_buckets_in_use
);
   import tdht_pkg::*;

`include "transaction_decision_hash_table_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MOD  = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CFG_W-1:0]  buckets_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MODE_W-1:0] mode_ff;
   logic [ID_W-1:0]   id_ff;
   logic [DEC_W-1:0]  dec_ff;
   logic [BKT_W-1:0]  bkt_ff;

   logic              strobe_ff, strobe_in;
   logic [DEC_W-1:0]  found_ff, found_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic              accept;
   logic [N_W-1:0]    divisor;
   logic              mod_done;
   logic [BKT_W-1:0]  mod_rem;
   rd_req_type        rd_req;
   wr_req_type        wr_req;
   row_type           rd_row;
   row_type           row_new;
   logic              row_changed;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // bucket count: zero or too large means the full table
   always_comb begin
      if (buckets_ff == '0 || 32'(buckets_ff) > 32'(NUM_BUCKETS)) begin
         divisor = N_W'(NUM_BUCKETS);
      end else begin
         divisor = N_W'(buckets_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buckets_ff <= BUCKETS_RESET;
      end else if (csr_valid && csr_ready) begin
         buckets_ff <= csr_buckets_in_use;
      end
   end

   tdht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .id        (req_transaction_id),
      .divisor   (divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   tdht_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .rd_row (rd_row)
   );

   // read the bucket row as soon as the remainder is ready
   assign rd_req.en   = mod_done && (state_ff == ST_MOD);
   assign rd_req.addr = mod_rem;

   // operation on the row read back
   always_comb begin
      logic hit;
      row_new     = rd_row;
      row_changed = 1'b0;
      hit         = 1'b0;
      found_in    = '0;
      status_in   = STAT_DONE;
      cnt_in      = cnt_ff;
      unique case (mode_ff)
         MODE_INSERT: begin
            for (int w = 0; w < WAYS; w++) begin
               if (!hit && !rd_row[w].valid) begin
                  hit              = 1'b1;
                  row_new[w].valid = 1'b1;
                  row_new[w].key   = id_ff;
                  row_new[w].value = dec_ff;
               end
            end
            if (hit) begin
               row_changed = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               status_in = STAT_FULL;
            end
         end
         MODE_SEARCH: begin
            for (int w = 0; w < WAYS; w++) begin
               if (!hit && rd_row[w].valid && rd_row[w].key == id_ff) begin
                  hit      = 1'b1;
                  found_in = rd_row[w].value;
               end
            end
            if (!hit) begin
               status_in = STAT_NOT_FOUND;
            end
         end
         MODE_REMOVE: begin
            for (int w = 0; w < WAYS; w++) begin
               if (!hit && rd_row[w].valid && rd_row[w].key == id_ff) begin
                  hit        = 1'b1;
                  row_new[w] = '0;
               end
            end
            if (hit) begin
               row_changed = 1'b1;
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         default: begin
            // unused mode: no change
         end
      endcase
   end

   assign wr_req.en   = (state_ff == ST_EXEC) && row_changed;
   assign wr_req.addr = bkt_ff;
   assign wr_req.row  = row_new;

   // control sequence
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (state_ff == ST_EXEC) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // item and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         id_ff   <= req_transaction_id;
         dec_ff  <= req_decision_value;
      end
      if (rd_req.en) begin
         bkt_ff <= mod_rem;
      end
      if (state_ff == ST_EXEC) begin
         found_ff  <= found_in;
         status_ff <= status_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_found_decision = found_ff;
   assign rsp_status         = status_ff;
   assign rsp_entry_count    = cnt_ff;

   `TDHT_ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_strobe, !busy)
   `TDHT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_strobe)
   `TDHT_ASSERT_IMPLIES(a_done_in_mod, clock, reset, mod_done, state_ff == ST_MOD)
   `TDHT_ASSERT_ALWAYS(a_count_bound, clock, reset, 32'(cnt_ff) <= 32'(SLOTS))

endmodule
